// ===== hdl/tse_pkg.sv =====
`default_nettype none

package tse_pkg;

    localparam int PACKET_BYTES_DEF = 188;

    localparam int POS_W = 8;
    localparam int AT_W = 9;
    localparam int OFF_W = AT_W + 1;

    localparam int TS_W = 33;
    localparam int PCR_W = 42;
    localparam int PCR_RAW_W = 48;
    localparam int TS_RAW_W = 40;
    localparam int PCR_EXT_W = 9;
    localparam int FOUND_W = 5;

    localparam int IN_TDATA_W = 8;
    localparam int IN_TUSER_W = 1;
    localparam int OUT_TDATA_W = 184;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [PCR_EXT_W-1:0] PCR_SCALE = 9'd300;

    localparam logic [POS_W-1:0] POS_SYNC = 8'd0;
    localparam logic [POS_W-1:0] POS_ERR = 8'd1;
    localparam logic [POS_W-1:0] POS_AFC = 8'd3;
    localparam logic [POS_W-1:0] POS_ALEN = 8'd4;
    localparam logic [POS_W-1:0] POS_AFLAGS = 8'd5;

    localparam logic [AT_W-1:0] PCR_AT = 9'd6;
    localparam logic [AT_W-1:0] PES_AT_PLAIN = 9'd4;
    localparam logic [AT_W-1:0] ADP_BODY_AT = 9'd5;
    localparam logic [AT_W-1:0] AT_PENDING = 9'h1FF;

    localparam int FND_PCR = 0;
    localparam int FND_OPCR = 1;
    localparam int FND_SPLICE = 2;
    localparam int FND_DTS = 3;
    localparam int FND_PTS = 4;

    localparam logic [7:0] SID_PROGRAM_MAP = 8'hBC;
    localparam logic [7:0] SID_PADDING = 8'hBE;
    localparam logic [7:0] SID_PRIVATE_2 = 8'hBF;
    localparam logic [7:0] SID_ECM = 8'hF0;
    localparam logic [7:0] SID_EMM = 8'hF1;
    localparam logic [7:0] SID_DIRECTORY = 8'hFF;
    localparam logic [7:0] SID_DSMCC = 8'hF2;
    localparam logic [7:0] SID_H222_E = 8'hF8;

    typedef struct packed {
        logic                 accepted;
        logic [FOUND_W-1:0]   found;
        logic [PCR_RAW_W-1:0] pcr_raw;
        logic [TS_RAW_W-1:0]  opcr_raw;
        logic [TS_RAW_W-1:0]  splice_raw;
        logic [TS_RAW_W-1:0]  dts_raw;
        logic [TS_RAW_W-1:0]  pts_raw;
    } tse_raw_t;

    function automatic logic excluded_id(input logic [7:0] id);
        logic r;
        case (id) inside
            SID_PROGRAM_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
            SID_EMM, SID_DIRECTORY, SID_DSMCC, SID_H222_E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // PES style timestamp: 3, 15 and 15 bits separated by marker bits.
    function automatic logic [TS_W-1:0] ts_decode(input logic [TS_RAW_W-1:0] r);
        return {r[35:33], r[31:24], r[23:17], r[15:8], r[7:1]};
    endfunction

    // Clock reference base: 32 bits and the top bit of the fifth byte.
    function automatic logic [TS_W-1:0] base_decode(input logic [TS_RAW_W-1:0] r);
        return r[TS_RAW_W-1:TS_RAW_W-TS_W];
    endfunction

    function automatic logic [OFF_W-1:0] offset(input logic [POS_W-1:0] p,
                                                input logic [AT_W-1:0] at);
        return OFF_W'(p) - OFF_W'(at);
    endfunction

    function automatic logic in_span(input logic [OFF_W-1:0] d,
                                     input logic [AT_W-1:0] lo,
                                     input logic [AT_W-1:0] hi);
        return !d[OFF_W-1] && (d[AT_W-1:0] >= lo) && (d[AT_W-1:0] <= hi);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tse_parser.sv =====
`default_nettype none

module tse_parser #(
    parameter int PACKET_BYTES = tse_pkg::PACKET_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tse_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [tse_pkg::IN_TUSER_W-1:0] s_tuser,
    input  logic                           out_space,
    output logic                           done,
    output tse_pkg::tse_raw_t              raw
);
    import tse_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

    localparam logic [AT_W-1:0] OFS_ZERO = 9'd0;
    localparam logic [AT_W-1:0] OFS_SC1 = 9'd1;
    localparam logic [AT_W-1:0] OFS_SC2 = 9'd2;
    localparam logic [AT_W-1:0] OFS_SID = 9'd3;
    localparam logic [AT_W-1:0] OFS_TS_LAST = 9'd4;
    localparam logic [AT_W-1:0] OFS_PCR_LAST = 9'd5;
    localparam logic [AT_W-1:0] OFS_PES_FLAGS = 9'd7;
    localparam logic [AT_W-1:0] OFS_PTS_FIRST = 9'd9;
    localparam logic [AT_W-1:0] OFS_PTS_LAST = 9'd13;
    localparam logic [AT_W-1:0] OFS_DTS_FIRST = 9'd14;
    localparam logic [AT_W-1:0] OFS_DTS_LAST = 9'd18;
    localparam logic [AT_W-1:0] REF_FIELD_LEN = 9'd6;
    localparam logic [AT_W-1:0] LTW_LEN = 9'd2;
    localparam logic [AT_W-1:0] RATE_LEN = 9'd3;

    logic                 collect_reg, collect_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 hdr_ok_reg, hdr_ok_next;
    logic                 afc_reg, afc_next;
    logic                 adp_reg, adp_next;
    logic                 pcr_en_reg, pcr_en_next;
    logic                 opcr_en_reg, opcr_en_next;
    logic                 priv_en_reg, priv_en_next;
    logic                 ext_en_reg, ext_en_next;
    logic                 spl_en_reg, spl_en_next;
    logic [AT_W-1:0]      opcr_at_reg, opcr_at_next;
    logic [AT_W-1:0]      priv_at_reg, priv_at_next;
    logic [AT_W-1:0]      ext_at_reg, ext_at_next;
    logic [AT_W-1:0]      spl_at_reg, spl_at_next;
    logic                 pes_ok_reg, pes_ok_next;
    logic [AT_W-1:0]      pes_at_reg, pes_at_next;
    logic                 pts_en_reg, pts_en_next;
    logic                 dts_en_reg, dts_en_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic [PCR_RAW_W-1:0] pcr_acc_reg, pcr_acc_next;
    logic [TS_RAW_W-1:0]  opcr_acc_reg, opcr_acc_next;
    logic [TS_RAW_W-1:0]  spl_acc_reg, spl_acc_next;
    logic [TS_RAW_W-1:0]  dts_acc_reg, dts_acc_next;
    logic [TS_RAW_W-1:0]  pts_acc_reg, pts_acc_next;

    logic                 take;
    logic                 start;
    logic [7:0]           b;
    logic [POS_W-1:0]     p;
    logic [AT_W-1:0]      p_ext;
    logic [OFF_W-1:0]     d_pcr, d_opcr, d_spl, d_pes;
    logic [AT_W-1:0]      opcr_at_calc, priv_at_calc;

    assign s_tready = !(collect_reg && (pos_reg == LAST_POS)) || out_space;

    always_comb
    begin
        take = s_tvalid && s_tready;
        start = s_tuser[0];
        b = s_tdata;
        p = start ? '0 : pos_reg;
        p_ext = AT_W'(p);

        d_pcr = offset(p, PCR_AT);
        d_opcr = offset(p, opcr_at_reg);
        d_spl = offset(p, spl_at_reg);
        d_pes = offset(p, pes_at_reg);

        opcr_at_calc = PCR_AT + (b[4] ? REF_FIELD_LEN : '0);
        priv_at_calc = opcr_at_calc + (b[3] ? REF_FIELD_LEN : '0) + AT_W'(b[2]);

        collect_next = collect_reg;
        pos_next = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        afc_next = afc_reg;
        adp_next = adp_reg;
        pcr_en_next = pcr_en_reg;
        opcr_en_next = opcr_en_reg;
        priv_en_next = priv_en_reg;
        ext_en_next = ext_en_reg;
        spl_en_next = spl_en_reg;
        opcr_at_next = opcr_at_reg;
        priv_at_next = priv_at_reg;
        ext_at_next = ext_at_reg;
        spl_at_next = spl_at_reg;
        pes_ok_next = pes_ok_reg;
        pes_at_next = pes_at_reg;
        pts_en_next = pts_en_reg;
        dts_en_next = dts_en_reg;
        found_next = found_reg;
        pcr_acc_next = pcr_acc_reg;
        opcr_acc_next = opcr_acc_reg;
        spl_acc_next = spl_acc_reg;
        dts_acc_next = dts_acc_reg;
        pts_acc_next = pts_acc_reg;
        done = 1'b0;

        // A packet start drops whatever was open and clears the field trackers.
        if (take && start)
        begin
            afc_next = 1'b0;
            adp_next = 1'b0;
            pcr_en_next = 1'b0;
            opcr_en_next = 1'b0;
            priv_en_next = 1'b0;
            ext_en_next = 1'b0;
            spl_en_next = 1'b0;
            pes_ok_next = 1'b0;
            pes_at_next = AT_PENDING;
            pts_en_next = 1'b0;
            dts_en_next = 1'b0;
            found_next = '0;
        end

        if (take && (start || collect_reg))
        begin
            if (p == POS_SYNC)
            begin
                hdr_ok_next = (b == SYNC_BYTE);
            end
            if (p == POS_ERR)
            begin
                hdr_ok_next = hdr_ok_reg && !b[7];
            end
            if (p == POS_AFC)
            begin
                afc_next = b[5];
                pes_ok_next = b[4];
                pes_at_next = b[5] ? AT_PENDING : PES_AT_PLAIN;
            end
            if (p == POS_ALEN)
            begin
                adp_next = afc_reg && (b != 8'd0);
                if (afc_reg)
                begin
                    pes_at_next = ADP_BODY_AT + AT_W'(b);
                end
            end
            if ((p == POS_AFLAGS) && adp_reg)
            begin
                pcr_en_next = b[4];
                opcr_en_next = b[3];
                priv_en_next = b[1];
                ext_en_next = b[0];
                opcr_at_next = opcr_at_calc;
                priv_at_next = priv_at_calc;
                ext_at_next = priv_at_calc;
            end

            // Transport private data is skipped by its own length byte.
            if (priv_en_reg && (p_ext == priv_at_reg))
            begin
                ext_at_next = priv_at_reg + AT_W'(1) + AT_W'(b);
            end
            if (ext_en_reg && (p_ext == ext_at_reg + AT_W'(1)))
            begin
                spl_en_next = b[5];
                spl_at_next = ext_at_reg + LTW_LEN + (b[7] ? LTW_LEN : '0)
                              + (b[6] ? RATE_LEN : '0);
            end

            if (pcr_en_reg && in_span(d_pcr, OFS_ZERO, OFS_PCR_LAST))
            begin
                pcr_acc_next = {pcr_acc_reg[PCR_RAW_W-9:0], b};
                if (d_pcr == OFF_W'(OFS_PCR_LAST))
                begin
                    found_next[FND_PCR] = 1'b1;
                end
            end
            if (opcr_en_reg && in_span(d_opcr, OFS_ZERO, OFS_TS_LAST))
            begin
                opcr_acc_next = {opcr_acc_reg[TS_RAW_W-9:0], b};
                if (d_opcr == OFF_W'(OFS_TS_LAST))
                begin
                    found_next[FND_OPCR] = 1'b1;
                end
            end
            if (spl_en_reg && in_span(d_spl, OFS_ZERO, OFS_TS_LAST))
            begin
                spl_acc_next = {spl_acc_reg[TS_RAW_W-9:0], b};
                if (d_spl == OFF_W'(OFS_TS_LAST))
                begin
                    found_next[FND_SPLICE] = 1'b1;
                end
            end

            // The PES header needs the 00 00 01 start code and an allowed stream id.
            if ((d_pes == OFF_W'(OFS_ZERO)) && (b != 8'h00))
            begin
                pes_ok_next = 1'b0;
            end
            if ((d_pes == OFF_W'(OFS_SC1)) && (b != 8'h00))
            begin
                pes_ok_next = 1'b0;
            end
            if ((d_pes == OFF_W'(OFS_SC2)) && (b != 8'h01))
            begin
                pes_ok_next = 1'b0;
            end
            if ((d_pes == OFF_W'(OFS_SID)) && excluded_id(b))
            begin
                pes_ok_next = 1'b0;
            end
            if ((d_pes == OFF_W'(OFS_PES_FLAGS)) && pes_ok_reg)
            begin
                pts_en_next = b[7];
                dts_en_next = b[7] && b[6];
            end
            if (pts_en_reg && in_span(d_pes, OFS_PTS_FIRST, OFS_PTS_LAST))
            begin
                pts_acc_next = {pts_acc_reg[TS_RAW_W-9:0], b};
                if (d_pes == OFF_W'(OFS_PTS_LAST))
                begin
                    found_next[FND_PTS] = 1'b1;
                end
            end
            if (dts_en_reg && in_span(d_pes, OFS_DTS_FIRST, OFS_DTS_LAST))
            begin
                dts_acc_next = {dts_acc_reg[TS_RAW_W-9:0], b};
                if (d_pes == OFF_W'(OFS_DTS_LAST))
                begin
                    found_next[FND_DTS] = 1'b1;
                end
            end

            if (p == LAST_POS)
            begin
                collect_next = 1'b0;
                pos_next = '0;
                done = 1'b1;
            end
            else
            begin
                collect_next = 1'b1;
                pos_next = p + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        raw.accepted = hdr_ok_next;
        raw.found = found_next;
        raw.pcr_raw = pcr_acc_next;
        raw.opcr_raw = opcr_acc_next;
        raw.splice_raw = spl_acc_next;
        raw.dts_raw = dts_acc_next;
        raw.pts_raw = pts_acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collect_reg <= 1'b0;
            pos_reg <= '0;
            hdr_ok_reg <= 1'b0;
            afc_reg <= 1'b0;
            adp_reg <= 1'b0;
            pcr_en_reg <= 1'b0;
            opcr_en_reg <= 1'b0;
            priv_en_reg <= 1'b0;
            ext_en_reg <= 1'b0;
            spl_en_reg <= 1'b0;
            opcr_at_reg <= '0;
            priv_at_reg <= '0;
            ext_at_reg <= '0;
            spl_at_reg <= '0;
            pes_ok_reg <= 1'b0;
            pes_at_reg <= AT_PENDING;
            pts_en_reg <= 1'b0;
            dts_en_reg <= 1'b0;
            found_reg <= '0;
        end
        else
        begin
            collect_reg <= collect_next;
            pos_reg <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            afc_reg <= afc_next;
            adp_reg <= adp_next;
            pcr_en_reg <= pcr_en_next;
            opcr_en_reg <= opcr_en_next;
            priv_en_reg <= priv_en_next;
            ext_en_reg <= ext_en_next;
            spl_en_reg <= spl_en_next;
            opcr_at_reg <= opcr_at_next;
            priv_at_reg <= priv_at_next;
            ext_at_reg <= ext_at_next;
            spl_at_reg <= spl_at_next;
            pes_ok_reg <= pes_ok_next;
            pes_at_reg <= pes_at_next;
            pts_en_reg <= pts_en_next;
            dts_en_reg <= dts_en_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pcr_acc_reg <= pcr_acc_next;
        opcr_acc_reg <= opcr_acc_next;
        spl_acc_reg <= spl_acc_next;
        dts_acc_reg <= dts_acc_next;
        pts_acc_reg <= pts_acc_next;
    end

endmodule

`default_nettype wire

// ===== hdl/tse_result.sv =====
`default_nettype none

module tse_result (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            done,
    input  tse_pkg::tse_raw_t               raw,
    output logic                            out_space,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tse_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tse_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - (1 + FOUND_W + PCR_W + 4 * TS_W);

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [FOUND_W-1:0]     f;
    logic [TS_W-1:0]        pcr_clk_base;
    logic [PCR_EXT_W-1:0]   pcr_ext;
    logic [PCR_W-1:0]       pcr_val;
    logic [TS_W-1:0]        opcr_val, spl_val, dts_val, pts_val;

    always_comb
    begin
        f = raw.accepted ? raw.found : '0;
        pcr_clk_base = base_decode(raw.pcr_raw[PCR_RAW_W-1:PCR_RAW_W-TS_RAW_W]);
        pcr_ext = raw.pcr_raw[PCR_EXT_W-1:0];
        pcr_val = PCR_W'(pcr_clk_base) * PCR_W'(PCR_SCALE) + PCR_W'(pcr_ext);
        opcr_val = base_decode(raw.opcr_raw);
        spl_val = ts_decode(raw.splice_raw);
        dts_val = ts_decode(raw.dts_raw);
        pts_val = ts_decode(raw.pts_raw);

        data_next = {
            {PAD_W{1'b0}},
            f[FND_PTS] ? pts_val : '0, f[FND_PTS],
            f[FND_DTS] ? dts_val : '0, f[FND_DTS],
            f[FND_SPLICE] ? spl_val : '0, f[FND_SPLICE],
            f[FND_OPCR] ? opcr_val : '0, f[FND_OPCR],
            f[FND_PCR] ? pcr_val : '0, f[FND_PCR],
            raw.accepted
        };
    end

    assign out_space = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (done)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ts_packet_timestamp_extractor_unit.sv =====
// Transport stream timestamp extractor.
// The input channel (s_*) carries the stream one byte per transaction, with
// s_tuser flagging the first byte of each packet. Bytes are counted within the
// fixed packet length, and the adaptation field and PES header are decoded on
// the fly as the bytes pass, so nothing of the packet is stored.
// After the last byte of a packet, one result transaction leaves on the output
// channel (m_*): the accepted flag, then PCR, OPCR base, splice DTS, PES DTS
// and PTS, each behind its found flag. Values of fields not found are zero.
// Throughput is one byte per cycle, but a packet's last byte waits while the
// output register is full. The result is valid in the cycle after the last
// byte is accepted, from a single output register. Bytes arriving outside
// an open packet are dropped; a new start flag abandons one without a result.
// When the receiver stalls, the held result stays on m_tdata and bytes keep
// flowing; only the last byte of the next packet waits until the register
// is free. Reset empties the output register and closes any open packet.
`default_nettype none

module ts_packet_timestamp_extractor_unit #(
    parameter int PACKET_BYTES = tse_pkg::PACKET_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // packet_byte
    input  logic [tse_pkg::IN_TDATA_W-1:0]  s_tdata,
    // packet_start
    input  logic [tse_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // packet_accepted, pcr_found, pcr_value, opcr_found, opcr_base,
    // splice_dts_found, splice_dts_value, pes_dts_found, pes_dts_value,
    // pts_found, pts_value, zero fill
    output logic [tse_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tse_pkg::*;

    tse_raw_t raw;
    logic     done;
    logic     out_space;

    tse_parser #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .out_space(out_space),
        .done(done),
        .raw(raw)
    );

    tse_result u_result (
        .clk(clk),
        .rst_n(rst_n),
        .done(done),
        .raw(raw),
        .out_space(out_space),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/tse_checker.sv =====
`default_nettype none

module tse_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tse_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tse_pkg::*;

    localparam int PCR_V_LO = 2;
    localparam int OPCR_F = PCR_V_LO + PCR_W;
    localparam int SPL_F = OPCR_F + 1 + TS_W;
    localparam int DTS_F = SPL_F + 1 + TS_W;
    localparam int PTS_F = DTS_F + 1 + TS_W;
    localparam int USED_W = PTS_F + 1 + TS_W;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_rejected_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("rejected packet carries values");

    a_values_gated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tdata[1] || m_tdata[OPCR_F-1:PCR_V_LO] == '0) &&
            (m_tdata[OPCR_F] || m_tdata[SPL_F-1:OPCR_F+1] == '0) &&
            (m_tdata[SPL_F] || m_tdata[DTS_F-1:SPL_F+1] == '0) &&
            (m_tdata[DTS_F] || m_tdata[PTS_F-1:DTS_F+1] == '0) &&
            (m_tdata[PTS_F] || m_tdata[USED_W-1:PTS_F+1] == '0))
        else $error("value present without its found flag");

    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted byte");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

endmodule

bind ts_packet_timestamp_extractor_unit tse_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
